[hw/rtl/quoted_delimited_tokenizer_assert.svh]
// Assertion macros for the tokenizer RTL.
`ifndef QUOTED_DELIMITED_TOKENIZER_ASSERT_SVH
`define QUOTED_DELIMITED_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define QDT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tokenizer assertion failed");
// expr must never be true outside reset
`define QDT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("tokenizer forbidden condition seen");
`else
`define QDT_ASSERT(lbl, clk, rst_n, prop)
`define QDT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[hw/rtl/qdt_pkg.sv]
// Shared types and constants of the quoted delimited tokenizer.
`default_nettype none

package qdt_pkg;

	localparam int CHAR_W = 8;
	localparam int CFG_W  = 64;

	localparam int DELIM_SLOTS_DEF = 8;
	localparam int QUOTE_SLOTS_DEF = 8;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// register reset values: space and TAB as delimiters
	localparam logic [CFG_W-1:0] DELIM_RESET = 64'h0000_0000_0000_0920;

	localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
	localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_BEL       = 8'h07;
	localparam logic [CHAR_W-1:0] CH_ESC       = 8'h1B;
	localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LOW_A     = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOW_E     = 8'h65;
	localparam logic [CHAR_W-1:0] CH_LOW_R     = 8'h72;
	localparam logic [CHAR_W-1:0] CH_LOW_T     = 8'h74;
	localparam logic [CHAR_W-1:0] CH_LOW_N     = 8'h6E;

	typedef enum logic [1:0] {
		REG_DELIM = 2'd0,
		REG_OPEN  = 2'd1,
		REG_CLOSE = 2'd2,
		REG_EMPTY = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		KIND_BYTE = 3'd0,
		KIND_END  = 3'd1,
		KIND_OK   = 3'd2,
		KIND_OPEN = 3'd3,
		KIND_ESC  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [CHAR_W-1:0]  ch;
		logic               last;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/quoted_delimited_tokenizer.sv]
// Line tokenizer with delimiter set, paired quotes and backslash escapes.
//
// One line enters as a stream of bytes (char_in, one word per handshake) and
// leaves as a stream of results: token bytes (kind 0), end-of-token markers
// (kind 1) and one closing status per line (2 success, 3 open quote, 4 bad
// escape). A zero byte, or an unescaped LF outside quotes, ends the line;
// after the status the tokenizer is back in its idle line state. "last"
// flags the final result caused by a given input byte; a backslash byte
// alone causes none. Delimiters and quote pairs live in 8-bit slots of the
// configuration registers (index 0 delimiters, 1 opening quotes, 2 closing
// quotes, 3 empty-field mode); a zero slot is unused, the lowest matching
// slot wins. Write the registers only between lines.
// Timing: a byte is registered at acceptance and resolved once the result
// queue has room, by one pass of slot compares and a shallow state update,
// which pushes its results into a four-entry result queue. Sustained rate is
// one byte per cycle while the queue has room; the output drains one result
// per cycle, so the results of a byte with two (end of token plus success)
// leave one after the other. Input is taken as long as the queue has room for
// two more results, so the input keeps moving while results wait to be taken.
`default_nettype none
`include "quoted_delimited_tokenizer_assert.svh"

module quoted_delimited_tokenizer
	import qdt_pkg::*;
#(
	parameter int DELIM_SLOTS = DELIM_SLOTS_DEF,
	parameter int QUOTE_SLOTS = QUOTE_SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration writes
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	// input bytes
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [CHAR_W-1:0] char_in,
	// results
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             kind,
	output logic [CHAR_W-1:0]      char_out,
	output logic                   last
);

	localparam int DW = DELIM_SLOTS * CHAR_W;
	localparam int QW = QUOTE_SLOTS * CHAR_W;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_DELIM  = 2'd1,
		PH_QUOTED = 2'd2
	} phase_t;

	// escape byte mapping: a e r t n become BEL ESC CR TAB LF
	function automatic logic [CHAR_W-1:0] map_escape(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] m;
		case (c)
			CH_LOW_A: m = CH_BEL;
			CH_LOW_E: m = CH_ESC;
			CH_LOW_R: m = CH_CR;
			CH_LOW_T: m = CH_TAB;
			CH_LOW_N: m = CH_LF;
			default:  m = c;
		endcase
		return m;
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers (always ready)
	// ---------------------------------------------------------------
	logic [DW-1:0] delim_q;
	logic [QW-1:0] open_q;
	logic [QW-1:0] close_set_q;
	logic          empty_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q     <= DELIM_RESET[DW-1:0];
			open_q      <= '0;
			close_set_q <= '0;
			empty_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DELIM: delim_q     <= cfg_data[DW-1:0];
				REG_OPEN:  open_q      <= cfg_data[QW-1:0];
				REG_CLOSE: close_set_q <= cfg_data[QW-1:0];
				REG_EMPTY: empty_q     <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic [CNT_W-1:0]  count_q;
	logic              room;
	logic              fire_s1;

	// room for the worst case of two results per byte
	assign room     = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign fire_s1  = valid_s1 && room;
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	// ---------------------------------------------------------------
	// Line state
	// ---------------------------------------------------------------
	phase_t            phase_q, phase_d;
	logic              esc_q, esc_d;
	logic              tok_q, tok_d;
	logic [CHAR_W-1:0] cq_q, cq_d;

	// control byte (escaped bytes act as a backslash) and data byte
	logic [CHAR_W-1:0] ctrl, data;
	logic              d_hit, q_hit;
	logic [CHAR_W-1:0] q_close;

	always_comb begin
		ctrl = esc_q ? CH_BACKSLASH : char_s1;
		data = esc_q ? map_escape(char_s1) : char_s1;
	end

	// parallel slot compares
	always_comb begin
		d_hit = 1'b0;
		for (int i = 0; i < DELIM_SLOTS; i++) begin
			if (delim_q[i*CHAR_W +: CHAR_W] != CH_NUL && delim_q[i*CHAR_W +: CHAR_W] == ctrl)
				d_hit = 1'b1;
		end
	end

	// lowest matching quote slot wins: scan from the top down
	always_comb begin
		q_hit   = 1'b0;
		q_close = CH_NUL;
		for (int i = QUOTE_SLOTS - 1; i >= 0; i--) begin
			if (open_q[i*CHAR_W +: CHAR_W] != CH_NUL && open_q[i*CHAR_W +: CHAR_W] == ctrl) begin
				q_hit   = 1'b1;
				q_close = close_set_q[i*CHAR_W +: CHAR_W];
			end
		end
	end

	// per-byte decision
	logic [1:0] n_res;
	res_t       r0, r1;
	logic       line_end;
	logic       go_idle;

	always_comb begin
		phase_d  = phase_q;
		esc_d    = esc_q;
		tok_d    = tok_q;
		cq_d     = cq_q;
		n_res    = 2'd0;
		r0       = '{kind: KIND_BYTE, ch: CH_NUL, last: 1'b0};
		r1       = '{kind: KIND_BYTE, ch: CH_NUL, last: 1'b0};
		go_idle  = 1'b0;
		line_end = (ctrl == CH_NUL) || (ctrl == CH_LF);

		if (!esc_q && char_s1 == CH_BACKSLASH) begin
			esc_d = 1'b1;
		end else if (esc_q && char_s1 == CH_NUL) begin
			n_res   = 2'd1;
			r0.kind = KIND_ESC;
			go_idle = 1'b1;
		end else begin
			esc_d = 1'b0;
			unique case (phase_q)
				PH_QUOTED: begin
					tok_d = 1'b1;
					if (ctrl == CH_NUL) begin
						n_res   = 2'd1;
						r0.kind = KIND_OPEN;
						go_idle = 1'b1;
					end else if (ctrl == cq_q) begin
						phase_d = PH_NORMAL;
					end else begin
						n_res = 2'd1;
						r0.ch = data;
					end
				end
				PH_DELIM: begin
					if (line_end) begin
						n_res   = 2'd1;
						r0.kind = KIND_OK;
						go_idle = 1'b1;
					end else if (q_hit) begin
						phase_d = PH_QUOTED;
						cq_d    = q_close;
					end else if (!d_hit) begin
						phase_d = PH_NORMAL;
						n_res   = 2'd1;
						r0.ch   = data;
						tok_d   = 1'b1;
					end else if (empty_q) begin
						n_res   = 2'd1;
						r0.kind = KIND_END;
					end
				end
				default: begin
					// normal phase (and the unused code)
					if (line_end) begin
						if (tok_q) begin
							n_res   = 2'd2;
							r0.kind = KIND_END;
							r1.kind = KIND_OK;
						end else begin
							n_res   = 2'd1;
							r0.kind = KIND_OK;
						end
						go_idle = 1'b1;
					end else if (d_hit) begin
						phase_d = PH_DELIM;
						if (tok_q) begin
							n_res   = 2'd1;
							r0.kind = KIND_END;
							tok_d   = 1'b0;
						end
					end else if (q_hit) begin
						phase_d = PH_QUOTED;
						cq_d    = q_close;
					end else begin
						phase_d = PH_NORMAL;
						n_res   = 2'd1;
						r0.ch   = data;
						tok_d   = 1'b1;
					end
				end
			endcase
		end

		if (go_idle) begin
			phase_d = PH_NORMAL;
			esc_d   = 1'b0;
			tok_d   = 1'b0;
			cq_d    = CH_NUL;
		end

		r0.last = (n_res == 2'd1);
		r1.last = (n_res == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			esc_q   <= 1'b0;
			tok_q   <= 1'b0;
			cq_q    <= CH_NUL;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			tok_q   <= tok_d;
			cq_q    <= cq_d;
		end
	end

	// ---------------------------------------------------------------
	// Result queue: up to two writes, one read per cycle
	// ---------------------------------------------------------------
	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic               pop;
	logic [1:0]         n_push;

	assign n_push = fire_s1 ? n_res : 2'd0;
	assign pop    = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wr_q] <= r0;
		if (n_push == 2'd2)
			mem_q[FIFO_AW'(wr_q + 1'b1)] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= FIFO_AW'(wr_q + FIFO_AW'(n_push));
			rd_q    <= FIFO_AW'(rd_q + FIFO_AW'(pop));
			count_q <= CNT_W'(count_q + CNT_W'(n_push) - CNT_W'(pop));
		end
	end

	assign out_valid = (count_q != '0);
	assign kind      = mem_q[rd_q].kind;
	assign char_out  = mem_q[rd_q].ch;
	assign last      = mem_q[rd_q].last;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// queue occupancy stays within its depth
	`QDT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(FIFO_DEPTH))
	// a delimiter always closes the token before the phase moves on
	`QDT_NEVER(a_delim_no_token, clk, arst_n, phase_q == PH_DELIM && tok_q)
	// a line status leaves the line state idle
	`QDT_ASSERT(a_status_idle, clk, arst_n, fire_s1 && go_idle |=> phase_q == PH_NORMAL && !tok_q && !esc_q && cq_q == CH_NUL)

endmodule

`default_nettype wire
